@@ hw/rtl/cpt_pkg.sv @@
// cpt_pkg: shared widths, word types and region codes for the closest-point unit.
// No dependencies; imported by every module of the block.
package cpt_pkg;

    // Coordinate format
    localparam int COORD_BITS = 20;
    localparam int FRAC_BITS  = 16;

    // Derived datapath widths (all exact, no rounding inside the block)
    localparam int DIF_W  = COORD_BITS + 1;          // vertex/point differences
    localparam int DOT_W  = 2 * DIF_W + 2;           // d1..d6
    localparam int HALF_W = (DOT_W + 1) / 2;         // split point for d*d products
    localparam int PP_HW  = 2 * HALF_W + 2;          // one partial product of d*d
    localparam int PRD_W  = 2 * DOT_W;               // full d*d product
    localparam int DET_W  = PRD_W + 1;               // va, vb, vc
    localparam int DEN_W  = DET_W + 2;               // numerators and denominators
    localparam int QUO_W  = DEN_W + FRAC_BITS;       // unsigned quotient bits
    localparam int Q_W    = QUO_W + 1;               // signed weight
    localparam int NCH    = 4;                       // weight chunks for weight*dir
    localparam int CH_W   = (Q_W + NCH - 1) / NCH;
    localparam int QX_W   = NCH * CH_W;
    localparam int PP_W   = CH_W + 1 + DIF_W;        // chunk*dir partial product
    localparam int OFF_W  = QX_W + DIF_W;            // full weight*dir product
    localparam int SUM_W  = OFF_W + 2;               // base + two offsets

    localparam int FRONT_STAGES = 6;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIF_W-1:0]      dif_t;
    typedef logic signed [DOT_W-1:0]      dot_t;
    typedef logic signed [PRD_W-1:0]      prd_t;
    typedef logic signed [DET_W-1:0]      det_t;
    typedef logic signed [DEN_W-1:0]      den_t;
    typedef logic signed [Q_W-1:0]        q_t;

    typedef coord_t [2:0] cvec_t;   // [0] x, [1] y, [2] z
    typedef dif_t   [2:0] dvec_t;

    typedef enum logic [2:0] {
        REG_VERT_A  = 3'd0,
        REG_VERT_B  = 3'd1,
        REG_EDGE_AB = 3'd2,
        REG_VERT_C  = 3'd3,
        REG_EDGE_AC = 3'd4,
        REG_EDGE_BC = 3'd5,
        REG_FACE    = 3'd6
    } region_t;

    typedef struct packed {
        coord_t query_x;
        coord_t query_y;
        coord_t query_z;
        coord_t vert_a_x;
        coord_t vert_a_y;
        coord_t vert_a_z;
        coord_t vert_b_x;
        coord_t vert_b_y;
        coord_t vert_b_z;
        coord_t vert_c_x;
        coord_t vert_c_y;
        coord_t vert_c_z;
    } in_word_t;

    typedef struct packed {
        coord_t  near_x;
        coord_t  near_y;
        coord_t  near_z;
        region_t region;
    } out_word_t;

    // Triangle geometry carried through the front pipeline
    typedef struct packed {
        cvec_t a;
        cvec_t b;
        cvec_t c;
        dvec_t ab;
        dvec_t ac;
        dvec_t bc;
    } geo_t;

    // Classified job: point = base + (w0*dir0 >>> F) + (w1*dir1 >>> F),
    // wk = floor(numk * 2^F / den), 0 when den is zero.
    typedef struct packed {
        region_t region;
        den_t    num0;
        den_t    num1;
        den_t    den;
        cvec_t   base;
        dvec_t   dir0;
        dvec_t   dir1;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ hw/rtl/cpt_front.sv @@
// cpt_front: accepts query words, computes the dot products and determinants,
// runs the region tests and emits one job per word. Depends on cpt_pkg.
module cpt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               query_valid,
    output logic               query_stall,
    input  cpt_pkg::in_word_t  query,
    input  cpt_pkg::q_stat_t   q_stat,
    output logic               push,
    output cpt_pkg::job_t      push_job
);
    import cpt_pkg::*;

    typedef struct packed {
        logic signed [PP_HW-1:0] hh;
        logic signed [PP_HW-1:0] hl;
        logic signed [PP_HW-1:0] lh;
        logic signed [PP_HW-1:0] ll;
    } ppart_t;

    function automatic dot_t dot3(dvec_t x, dvec_t y);
        logic signed [2*DIF_W-1:0] p0;
        logic signed [2*DIF_W-1:0] p1;
        logic signed [2*DIF_W-1:0] p2;
        dot_t s;
        p0 = x[0] * y[0];
        p1 = x[1] * y[1];
        p2 = x[2] * y[2];
        s  = p0 + p1 + p2;
        return s;
    endfunction

    // d*d split into four narrow partials
    function automatic ppart_t mul_split(dot_t x, dot_t y);
        logic signed [DOT_W-HALF_W-1:0] xh;
        logic signed [DOT_W-HALF_W-1:0] yh;
        logic signed [HALF_W:0]         xl;
        logic signed [HALF_W:0]         yl;
        ppart_t r;
        xh = x[DOT_W-1:HALF_W];
        yh = y[DOT_W-1:HALF_W];
        xl = {1'b0, x[HALF_W-1:0]};
        yl = {1'b0, y[HALF_W-1:0]};
        r.hh = xh * yh;
        r.hl = xh * yl;
        r.lh = xl * yh;
        r.ll = xl * yl;
        return r;
    endfunction

    function automatic prd_t mul_join(ppart_t p);
        prd_t hh;
        prd_t hl;
        prd_t lh;
        prd_t ll;
        prd_t s;
        hh = p.hh;
        hl = p.hl;
        lh = p.lh;
        ll = p.ll;
        s  = (hh <<< (2 * HALF_W)) + ((hl + lh) <<< HALF_W) + ll;
        return s;
    endfunction

    logic [FRONT_STAGES-1:0] vld_reg;
    logic                    adv;

    // stage 1
    geo_t   s1_geo_reg;
    dvec_t  s1_ap_reg;
    dvec_t  s1_bp_reg;
    dvec_t  s1_cp_reg;
    geo_t   s1_geo_next;
    dvec_t  s1_ap_next;
    dvec_t  s1_bp_next;
    dvec_t  s1_cp_next;
    // stage 2..5
    geo_t   s2_geo_reg;
    dot_t   s2_dot_reg [6];
    geo_t   s3_geo_reg;
    dot_t   s3_dot_reg [6];
    ppart_t s3_pp_reg  [6];
    geo_t   s4_geo_reg;
    dot_t   s4_dot_reg [6];
    prd_t   s4_prd_reg [6];
    geo_t   s5_geo_reg;
    dot_t   s5_dot_reg [6];
    det_t   s5_va_reg;
    det_t   s5_vb_reg;
    det_t   s5_vc_reg;
    // stage 6
    job_t   job_reg;
    job_t   job_next;

    assign adv         = !(vld_reg[FRONT_STAGES-1] && q_stat.full);
    assign query_stall = !adv;
    assign push        = vld_reg[FRONT_STAGES-1] && !q_stat.full;
    assign push_job    = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], query_valid};
        end
    end

    always_comb
    begin
        cvec_t p;
        p[0] = query.query_x;
        p[1] = query.query_y;
        p[2] = query.query_z;
        s1_geo_next.a[0] = query.vert_a_x;
        s1_geo_next.a[1] = query.vert_a_y;
        s1_geo_next.a[2] = query.vert_a_z;
        s1_geo_next.b[0] = query.vert_b_x;
        s1_geo_next.b[1] = query.vert_b_y;
        s1_geo_next.b[2] = query.vert_b_z;
        s1_geo_next.c[0] = query.vert_c_x;
        s1_geo_next.c[1] = query.vert_c_y;
        s1_geo_next.c[2] = query.vert_c_z;
        for (int i = 0; i < 3; i++)
        begin
            s1_geo_next.ab[i] = s1_geo_next.b[i] - s1_geo_next.a[i];
            s1_geo_next.ac[i] = s1_geo_next.c[i] - s1_geo_next.a[i];
            s1_geo_next.bc[i] = s1_geo_next.c[i] - s1_geo_next.b[i];
            s1_ap_next[i]     = p[i] - s1_geo_next.a[i];
            s1_bp_next[i]     = p[i] - s1_geo_next.b[i];
            s1_cp_next[i]     = p[i] - s1_geo_next.c[i];
        end
    end

    // Region tests in priority order, then the job for the chosen region
    always_comb
    begin
        logic signed [DOT_W:0] e43;
        logic signed [DOT_W:0] e56;
        dot_t d1;
        dot_t d2;
        dot_t d3;
        dot_t d4;
        dot_t d5;
        dot_t d6;
        d1  = s5_dot_reg[0];
        d2  = s5_dot_reg[1];
        d3  = s5_dot_reg[2];
        d4  = s5_dot_reg[3];
        d5  = s5_dot_reg[4];
        d6  = s5_dot_reg[5];
        e43 = d4 - d3;
        e56 = d5 - d6;
        job_next.num0 = '0;
        job_next.num1 = '0;
        job_next.den  = '0;
        job_next.base = s5_geo_reg.a;
        job_next.dir0 = '0;
        job_next.dir1 = '0;
        priority if (d1 <= 0 && d2 <= 0)
        begin
            job_next.region = REG_VERT_A;
        end
        else if (d3 >= 0 && e43 <= 0)
        begin
            job_next.region = REG_VERT_B;
            job_next.base   = s5_geo_reg.b;
        end
        else if (s5_vc_reg <= 0 && d1 >= 0 && d3 <= 0)
        begin
            job_next.region = REG_EDGE_AB;
            job_next.num0   = d1;
            job_next.den    = d1 - d3;
            job_next.dir0   = s5_geo_reg.ab;
        end
        else if (d6 >= 0 && e56 <= 0)
        begin
            job_next.region = REG_VERT_C;
            job_next.base   = s5_geo_reg.c;
        end
        else if (s5_vb_reg <= 0 && d2 >= 0 && d6 <= 0)
        begin
            job_next.region = REG_EDGE_AC;
            job_next.num0   = d2;
            job_next.den    = d2 - d6;
            job_next.dir0   = s5_geo_reg.ac;
        end
        else if (s5_va_reg <= 0 && e43 >= 0 && e56 >= 0)
        begin
            job_next.region = REG_EDGE_BC;
            job_next.num0   = e43;
            job_next.den    = e43 + e56;
            job_next.base   = s5_geo_reg.b;
            job_next.dir0   = s5_geo_reg.bc;
        end
        else
        begin
            job_next.region = REG_FACE;
            job_next.num0   = s5_vb_reg;
            job_next.num1   = s5_vc_reg;
            job_next.den    = s5_va_reg + s5_vb_reg + s5_vc_reg;
            job_next.dir0   = s5_geo_reg.ab;
            job_next.dir1   = s5_geo_reg.ac;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_geo_reg <= s1_geo_next;
            s1_ap_reg  <= s1_ap_next;
            s1_bp_reg  <= s1_bp_next;
            s1_cp_reg  <= s1_cp_next;

            s2_geo_reg    <= s1_geo_reg;
            s2_dot_reg[0] <= dot3(s1_geo_reg.ab, s1_ap_reg);
            s2_dot_reg[1] <= dot3(s1_geo_reg.ac, s1_ap_reg);
            s2_dot_reg[2] <= dot3(s1_geo_reg.ab, s1_bp_reg);
            s2_dot_reg[3] <= dot3(s1_geo_reg.ac, s1_bp_reg);
            s2_dot_reg[4] <= dot3(s1_geo_reg.ab, s1_cp_reg);
            s2_dot_reg[5] <= dot3(s1_geo_reg.ac, s1_cp_reg);

            // d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
            s3_geo_reg   <= s2_geo_reg;
            s3_dot_reg   <= s2_dot_reg;
            s3_pp_reg[0] <= mul_split(s2_dot_reg[0], s2_dot_reg[3]);
            s3_pp_reg[1] <= mul_split(s2_dot_reg[2], s2_dot_reg[1]);
            s3_pp_reg[2] <= mul_split(s2_dot_reg[4], s2_dot_reg[1]);
            s3_pp_reg[3] <= mul_split(s2_dot_reg[0], s2_dot_reg[5]);
            s3_pp_reg[4] <= mul_split(s2_dot_reg[2], s2_dot_reg[5]);
            s3_pp_reg[5] <= mul_split(s2_dot_reg[4], s2_dot_reg[3]);

            s4_geo_reg <= s3_geo_reg;
            s4_dot_reg <= s3_dot_reg;
            for (int k = 0; k < 6; k++)
            begin
                s4_prd_reg[k] <= mul_join(s3_pp_reg[k]);
            end

            s5_geo_reg <= s4_geo_reg;
            s5_dot_reg <= s4_dot_reg;
            s5_vc_reg  <= s4_prd_reg[0] - s4_prd_reg[1];
            s5_vb_reg  <= s4_prd_reg[2] - s4_prd_reg[3];
            s5_va_reg  <= s4_prd_reg[4] - s4_prd_reg[5];

            job_reg <= job_next;
        end
    end

endmodule

@@ hw/rtl/cpt_queue.sv @@
// cpt_queue: short job FIFO between the classifying front and the solving back.
// Depends on cpt_pkg (job_t, q_stat_t, QDEPTH).
module cpt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cpt_pkg::job_t     push_job,
    input  logic              pop,
    output cpt_pkg::job_t     pop_job,
    output cpt_pkg::q_stat_t  stat
);
    import cpt_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_next;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ hw/rtl/cpt_back.sv @@
// cpt_back: solves queued jobs: pipelined restoring division for the weights,
// chunked weight*direction products, offset sum and saturation. Depends on cpt_pkg.
module cpt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cpt_pkg::job_t      job,
    input  cpt_pkg::q_stat_t   q_stat,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output cpt_pkg::out_word_t result
);
    import cpt_pkg::*;

    localparam int NB = QUO_W + 4;   // prep, QUO_W divide steps, fix, mul, offset

    typedef struct packed {
        logic [DEN_W-1:0] r;
        logic [QUO_W-1:0] nq;   // dividend bits in, quotient bits out
    } div_t;

    typedef struct packed {
        region_t region;
        cvec_t   base;
        dvec_t   dir0;
        dvec_t   dir1;
    } tail_t;

    typedef struct packed {
        tail_t            tail;
        logic [DEN_W-1:0] ud;
        logic             neg0;
        logic             neg1;
        logic             dz;
    } side_t;

    typedef logic signed [PP_W-1:0]  pp_t;
    typedef logic signed [OFF_W-1:0] off_t;

    function automatic logic [DEN_W-1:0] mag(den_t x);
        logic [DEN_W-1:0] m;
        m = x[DEN_W-1] ? (~x + 1'b1) : x;
        return m;
    endfunction

    function automatic div_t div_step(div_t s, logic [DEN_W-1:0] d);
        logic [DEN_W:0] rt;
        div_t           o;
        rt = {s.r, s.nq[QUO_W-1]};
        if (rt >= {1'b0, d})
        begin
            o.r  = DEN_W'(rt - {1'b0, d});
            o.nq = {s.nq[QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.r  = rt[DEN_W-1:0];
            o.nq = {s.nq[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    logic        adv;
    logic [NB-1:0] vld_reg;
    logic        out_v_reg;
    out_word_t   out_reg;
    out_word_t   out_next;

    side_t       side_reg [QUO_W+1];
    div_t        lane_reg [QUO_W+1][2];
    side_t       side_next;
    div_t        lane_next [2];

    tail_t       fix_tail_reg;
    q_t          fix_q_reg  [2];
    q_t          fix_q_next [2];
    tail_t       mul_tail_reg;
    pp_t         pp_reg  [2][3][NCH];
    pp_t         pp_next [2][3][NCH];
    tail_t       off_tail_reg;
    off_t        off_reg  [2][3];
    off_t        off_next [2][3];

    // whole back pipeline moves together; bubbles ride along
    assign adv          = !(out_v_reg && result_stall);
    assign pop          = adv && !q_stat.empty;
    assign result_valid = out_v_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg   <= {vld_reg[NB-2:0], pop};
            out_v_reg <= vld_reg[NB-1];
        end
    end

    // job -> magnitudes and signs
    always_comb
    begin
        side_next.tail.region = job.region;
        side_next.tail.base   = job.base;
        side_next.tail.dir0   = job.dir0;
        side_next.tail.dir1   = job.dir1;
        side_next.ud          = mag(job.den);
        side_next.neg0        = job.num0[DEN_W-1] ^ job.den[DEN_W-1];
        side_next.neg1        = job.num1[DEN_W-1] ^ job.den[DEN_W-1];
        side_next.dz          = (job.den == '0);
        lane_next[0].r        = '0;
        lane_next[0].nq       = {mag(job.num0), {FRAC_BITS{1'b0}}};
        lane_next[1].r        = '0;
        lane_next[1].nq       = {mag(job.num1), {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0]    <= side_next;
            lane_reg[0][0] <= lane_next[0];
            lane_reg[0][1] <= lane_next[1];
        end
    end

    // one quotient bit per stage, both lanes share the divisor
    for (genvar s = 0; s < QUO_W; s++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[s+1]    <= side_reg[s];
                lane_reg[s+1][0] <= div_step(lane_reg[s][0], side_reg[s].ud);
                lane_reg[s+1][1] <= div_step(lane_reg[s][1], side_reg[s].ud);
            end
        end
    end

    // floor for negative quotients; zero divisor gives weight 0
    always_comb
    begin
        q_t   qm;
        logic rnz;
        logic neg;
        for (int l = 0; l < 2; l++)
        begin
            qm  = {1'b0, lane_reg[QUO_W][l].nq};
            rnz = |lane_reg[QUO_W][l].r;
            neg = (l == 0) ? side_reg[QUO_W].neg0 : side_reg[QUO_W].neg1;
            if (side_reg[QUO_W].dz)
            begin
                fix_q_next[l] = '0;
            end
            else if (neg)
            begin
                fix_q_next[l] = rnz ? ~qm : ~qm + 1'b1;
            end
            else
            begin
                fix_q_next[l] = qm;
            end
        end
    end

    // weight split in chunks, each times one direction component
    always_comb
    begin
        logic signed [QX_W-1:0] qx;
        logic signed [CH_W:0]   ch;
        dvec_t                  dir;
        for (int l = 0; l < 2; l++)
        begin
            qx  = fix_q_reg[l];
            dir = (l == 0) ? fix_tail_reg.dir0 : fix_tail_reg.dir1;
            for (int k = 0; k < NCH; k++)
            begin
                if (k == NCH - 1)
                begin
                    ch = {qx[QX_W-1], qx[k*CH_W +: CH_W]};
                end
                else
                begin
                    ch = {1'b0, qx[k*CH_W +: CH_W]};
                end
                for (int i = 0; i < 3; i++)
                begin
                    pp_next[l][i][k] = ch * dir[i];
                end
            end
        end
    end

    // rebuild weight*dir, arithmetic shift floors the offset
    always_comb
    begin
        off_t acc;
        off_t term;
        for (int l = 0; l < 2; l++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc = '0;
                for (int k = 0; k < NCH; k++)
                begin
                    term = pp_reg[l][i][k];
                    acc  = acc + (term <<< (k * CH_W));
                end
                off_next[l][i] = acc >>> FRAC_BITS;
            end
        end
    end

    // base + offsets, clamp to the coordinate range
    always_comb
    begin
        logic signed [SUM_W-1:0] tot;
        logic signed [SUM_W-1:0] sat_hi;
        logic signed [SUM_W-1:0] sat_lo;
        logic signed [SUM_W-1:0] base_x;
        coord_t                  nc [3];
        sat_hi = {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
        sat_lo = {{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
        for (int i = 0; i < 3; i++)
        begin
            base_x = off_tail_reg.base[i];
            tot    = base_x + off_reg[0][i] + off_reg[1][i];
            if (tot > sat_hi)
            begin
                nc[i] = sat_hi[COORD_BITS-1:0];
            end
            else if (tot < sat_lo)
            begin
                nc[i] = sat_lo[COORD_BITS-1:0];
            end
            else
            begin
                nc[i] = tot[COORD_BITS-1:0];
            end
        end
        out_next.near_x = nc[0];
        out_next.near_y = nc[1];
        out_next.near_z = nc[2];
        out_next.region = off_tail_reg.region;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fix_tail_reg <= side_reg[QUO_W].tail;
            fix_q_reg    <= fix_q_next;
            mul_tail_reg <= fix_tail_reg;
            pp_reg       <= pp_next;
            off_tail_reg <= mul_tail_reg;
            off_reg      <= off_next;
            out_reg      <= out_next;
        end
    end

endmodule

@@ hw/rtl/closest_point_on_triangle_unit.sv @@
// closest_point_on_triangle_unit: top level, front classifier + job queue + back solver.
// Depends on cpt_pkg, cpt_front, cpt_queue, cpt_back.
//
//  channel | valid         | stall         | word
//  --------+---------------+---------------+---------------------------------------
//  query   | query_valid   | query_stall   | query  (P, A, B, C; signed fixed point)
//  result  | result_valid  | result_stall  | result (nearest point + region code)
//
// One word per cycle sustained while result_stall is low. A word passes the front stages,
// the job queue, then the back's prep, divide (107-step restoring divider in the default
// widths), fix, mul, offset and output registers; the per-bit divider sets the latency.
// Async active-low reset clears all valid bits, queue pointers and count.
// query_stall rises only when the front's last stage holds a job and the queue
// is full; result_stall freezes the back only, the front keeps filling the queue.
//
// Region tests run in the fixed order vertex A, vertex B, edge AB, vertex C,
// edge AC, edge BC, face. Every region is solved as
//   base + (w0*dir0 >>> F) + (w1*dir1 >>> F),  wk = floor(numk*2^F / den)
// with vertices using zero weights and a zero denominator giving weight 0.
module closest_point_on_triangle_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               query_valid,
    output logic               query_stall,
    input  cpt_pkg::in_word_t  query,
    output logic               result_valid,
    input  logic               result_stall,
    output cpt_pkg::out_word_t result
);
    import cpt_pkg::*;

    job_t    push_job;
    job_t    pop_job;
    logic    push;
    logic    pop;
    q_stat_t q_stat;

    cpt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_stall (query_stall),
        .query       (query),
        .q_stat      (q_stat),
        .push        (push),
        .push_job    (push_job)
    );

    cpt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    cpt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (pop_job),
        .q_stat       (q_stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("job pushed into full queue");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty))
        else $error("job popped from empty queue");

    // input backpressure comes only from a full queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> q_stat.full)
        else $error("query stalled while queue has room");

endmodule
